### src/sefr_pkg.sv
// ----------------------------------------------------------------------------
// sefr_pkg
// shared types and constants of the sync/escape/checksum frame receiver
// ----------------------------------------------------------------------------
package sefr_pkg;

    typedef enum logic [2:0] {
        EV_IGNORED  = 3'd0,
        EV_START    = 3'd1,
        EV_ESCAPE   = 3'd2,
        EV_BODY     = 3'd3,
        EV_GOOD     = 3'd4,
        EV_BAD_SUM  = 3'd5,
        EV_OVERFLOW = 3'd6
    } event_t;

    localparam logic CFG_SYNC   = 1'b0;
    localparam logic CFG_ESCAPE = 1'b1;

    localparam logic [7:0] SYNC_RESET   = 8'd224;
    localparam logic [7:0] ESCAPE_RESET = 8'd208;

    // first body byte index that may close a frame, and offset of length
    localparam int unsigned MIN_END_COUNT = 4;
    localparam int unsigned LEN_OFFSET    = 3;
    localparam int unsigned LEN_INDEX     = 2;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] body_byte;
        logic [5:0] body_index;
    } result_t;

endpackage

### src/sefr_in_reg.sv
// ----------------------------------------------------------------------------
// sefr_in_reg
// input register: holds one received byte until the framing logic takes it
// ----------------------------------------------------------------------------
module sefr_in_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] rx_byte
    input  logic             take,
    output sefr_pkg::item_t  item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

### src/sefr_core.sv
// ----------------------------------------------------------------------------
// sefr_core
// framing state and per-byte decode: sync, escape, length, checksum, overflow
// ----------------------------------------------------------------------------
module sefr_core
#(
    parameter int unsigned MAX_FRAME = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         sync_value,
    input  logic [7:0]         escape_value,
    output sefr_pkg::result_t  result
);

    localparam int unsigned CW   = $clog2(MAX_FRAME + 1);
    localparam int unsigned CMPW = (CW > 9) ? CW : 9;

    logic          in_frame_reg;
    logic          in_frame_next;
    logic          esc_reg;
    logic          esc_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    sum_reg;
    logic [7:0]    sum_next;
    logic [7:0]    len_reg;
    logic [7:0]    len_next;

    logic [7:0]      data;
    logic [CMPW-1:0] count_w;
    logic [CMPW-1:0] end_count;

    assign data      = esc_reg ? (rx_byte + 8'd1) : rx_byte;
    assign count_w   = CMPW'(count_reg);
    assign end_count = CMPW'(len_reg) + CMPW'(sefr_pkg::LEN_OFFSET);

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        esc_next          = esc_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        len_next          = len_reg;
        result.event_res  = sefr_pkg::EV_IGNORED;
        result.body_byte  = 8'd0;
        result.body_index = 6'd0;

        if (rx_byte == sync_value)
        begin
            in_frame_next    = 1'b1;
            esc_next         = 1'b0;
            count_next       = '0;
            sum_next         = 8'd0;
            result.event_res = sefr_pkg::EV_START;
        end
        else if (!in_frame_reg)
        begin
            result.event_res = sefr_pkg::EV_IGNORED;
        end
        else if (rx_byte == escape_value)
        begin
            esc_next         = 1'b1;
            result.event_res = sefr_pkg::EV_ESCAPE;
        end
        else
        begin
            esc_next = 1'b0;
            // length match wins over the size limit
            if (count_w >= CMPW'(sefr_pkg::MIN_END_COUNT) && count_w == end_count)
            begin
                in_frame_next    = 1'b0;
                result.event_res = (sum_reg == data) ? sefr_pkg::EV_GOOD
                                                     : sefr_pkg::EV_BAD_SUM;
            end
            else if (count_w >= CMPW'(MAX_FRAME))
            begin
                in_frame_next    = 1'b0;
                result.event_res = sefr_pkg::EV_OVERFLOW;
            end
            else
            begin
                if (count_w == CMPW'(sefr_pkg::LEN_INDEX))
                begin
                    len_next = data;
                end
                count_next        = count_reg + CW'(1);
                sum_next          = sum_reg + data;
                result.event_res  = sefr_pkg::EV_BODY;
                result.body_byte  = data;
                result.body_index = count_w[5:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= 8'd0;
            len_reg      <= 8'd0;
        end
        else if (take)
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            len_reg      <= len_next;
        end
    end

endmodule

### src/sefr_out_reg.sv
// ----------------------------------------------------------------------------
// sefr_out_reg
// result register: one event per byte, held until the sink takes the beat
// ----------------------------------------------------------------------------
module sefr_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               take,
    input  sefr_pkg::result_t  result,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [7:0] body_byte, [13:8] body_index, [15:14] zero
    output logic [2:0]         m_tuser    // [2:0] event_res
);

    logic              valid_reg;
    logic              valid_next;
    sefr_pkg::result_t res_reg;

    assign take = item_valid && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg.body_index, res_reg.body_byte};
    assign m_tuser  = res_reg.event_res;

endmodule

### src/sync_escape_checksum_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_escape_checksum_frame_receiver
// byte-stream frame receiver with sync restart, escape, length and checksum
// ----------------------------------------------------------------------------
// Takes one received byte per beat and returns exactly one event beat per
// byte. A new byte is accepted every clock cycle while the sink takes the
// event beats; each byte passes an input register and then a result
// register, which presents its event beat. The rate is set by the
// combinational framing decode that updates count, running sum and escape
// flag between those registers. The user writes sync_value and escape_value
// through the cfg port only while the block is idle; the block itself does
// not enforce this. body_index reports the low 6 bits of the body position.
module sync_escape_checksum_frame_receiver
#(
    parameter int unsigned MAX_FRAME = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] body_byte, [13:8] body_index, [15:14] zero
    output logic [2:0]  m_tuser     // [2:0] event_res
);

    logic [7:0]        sync_reg;
    logic [7:0]        escape_reg;
    sefr_pkg::item_t   item;
    sefr_pkg::result_t result;
    logic              take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg   <= sefr_pkg::SYNC_RESET;
            escape_reg <= sefr_pkg::ESCAPE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sefr_pkg::CFG_SYNC:   sync_reg   <= cfg_data;
                sefr_pkg::CFG_ESCAPE: escape_reg <= cfg_data;
                default:              sync_reg   <= sync_reg;
            endcase
        end
    end

    sefr_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .item     (item)
    );

    sefr_core
    #(
        .MAX_FRAME (MAX_FRAME)
    )
    u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .rx_byte      (item.rx_byte),
        .sync_value   (sync_reg),
        .escape_value (escape_reg),
        .result       (result)
    );

    sefr_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .take       (take),
        .result     (result),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### tb/sv/sefr_event_check.sv
// ----------------------------------------------------------------------------
// sefr_event_check
// watches the receiver's channels, predicts every event beat and compares
// ----------------------------------------------------------------------------
// Every accepted input byte is run through a local copy of the framing
// decoder: sync restart, escape, length capture, checksum end and overflow
// drop. Each predicted event waits in order until the next output beat,
// and that beat is compared field by field. Register writes update the local
// copies of the sync and escape values.
module sefr_event_check
    import sefr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [7:0] body_byte, [13:8] body_index, [15:14] zero
    input  logic [2:0]  m_tuser,    // [2:0] event_res
    output int          mismatch_count,
    output int          events_pending,
    output int          frames_good,
    output int          frames_bad,
    output int          frames_dropped
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] sync_byte;
    logic [7:0] escape_byte;
    logic       in_frame;
    logic       escape_armed;
    logic [8:0] body_count;
    logic [7:0] body_sum;
    logic [7:0] frame_len;

    result_t    expected_events[$];
    result_t    seen;
    result_t    wanted;

    // one received byte through the framing decoder
    task automatic frame_decode(input logic [7:0] raw, output result_t ev);
        logic [7:0] b;
        b = raw;
        ev.event_res  = EV_IGNORED;
        ev.body_byte  = 8'd0;
        ev.body_index = 6'd0;
        if (b == sync_byte)
        begin
            body_count   = 9'd0;
            body_sum     = 8'd0;
            in_frame     = 1'b1;
            escape_armed = 1'b0;
            ev.event_res = EV_START;
        end
        else if (in_frame && b == escape_byte)
        begin
            escape_armed = 1'b1;
            ev.event_res = EV_ESCAPE;
        end
        else if (in_frame)
        begin
            if (escape_armed)
            begin
                b            = b + 8'd1;
                escape_armed = 1'b0;
            end
            // length check wins over the size check
            if (body_count >= MIN_END_COUNT && body_count == frame_len + LEN_OFFSET)
            begin
                in_frame     = 1'b0;
                ev.event_res = (body_sum == b) ? EV_GOOD : EV_BAD_SUM;
            end
            else if (body_count >= MAX_FRAME)
            begin
                in_frame     = 1'b0;
                ev.event_res = EV_OVERFLOW;
            end
            else
            begin
                if (body_count == LEN_INDEX)
                    frame_len = b;
                ev.event_res  = EV_BODY;
                ev.body_byte  = b;
                ev.body_index = body_count[5:0];
                body_count    = body_count + 9'd1;
                body_sum      = body_sum + b;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte      = SYNC_RESET;
            escape_byte    = ESCAPE_RESET;
            in_frame       = 1'b0;
            escape_armed   = 1'b0;
            body_count     = 9'd0;
            body_sum       = 8'd0;
            frame_len      = 8'd0;
            mismatch_count = 0;
            frames_good    = 0;
            frames_bad     = 0;
            frames_dropped = 0;
            expected_events.delete();
            events_pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.event_res  = event_t'(m_tuser);
                seen.body_byte  = m_tdata[7:0];
                seen.body_index = m_tdata[13:8];
                if (expected_events.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected: event %0d byte %h index %0d",
                             $time, seen.event_res, seen.body_byte, seen.body_index);
                end
                else
                begin
                    wanted = expected_events.pop_front();
                    if (seen.event_res !== wanted.event_res)
                    begin
                        mismatch_count++;
                        $display("%0t: event_res expected %0d, got %0d",
                                 $time, wanted.event_res, seen.event_res);
                    end
                    if (seen.body_byte !== wanted.body_byte)
                    begin
                        mismatch_count++;
                        $display("%0t: body_byte expected %h, got %h",
                                 $time, wanted.body_byte, seen.body_byte);
                    end
                    if (seen.body_index !== wanted.body_index)
                    begin
                        mismatch_count++;
                        $display("%0t: body_index expected %0d, got %0d",
                                 $time, wanted.body_index, seen.body_index);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SYNC)
                    sync_byte = cfg_data;
                else
                    escape_byte = cfg_data;
            end

            if (s_tvalid && s_tready)
            begin
                frame_decode(s_tdata, wanted);
                expected_events.push_back(wanted);
                case (wanted.event_res)
                    EV_GOOD:     frames_good++;
                    EV_BAD_SUM:  frames_bad++;
                    EV_OVERFLOW: frames_dropped++;
                    default:     ;
                endcase
            end

            events_pending = expected_events.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the sync/escape/checksum frame receiver
// ----------------------------------------------------------------------------
// A short directed byte sequence covers the framing corner cases, then six
// register settings each carry a stretch of random frames: mostly well-formed
// frames with random payload, escapes and lengths, some cut short, some with
// bad checksums or too long, mixed with raw noise. Both sides stall at random
// in two of three idling phases. Checking is done by sefr_event_check.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sefr_pkg::*;

    localparam int unsigned MAX_FRAME   = 64;
    localparam int          STALL_LIMIT = 2000;
    localparam int          SEG_BYTES   = 300;
    localparam int          NUM_SEGS    = 6;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_SYNC;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // [7:0] body_byte, [13:8] body_index, [15:14] zero
    logic [2:0]  m_tuser;            // [2:0] event_res

    int mismatch_count;
    int events_pending;
    int frames_good;
    int frames_bad;
    int frames_dropped;

    int         send_idle_pct = 7;
    int         recv_idle_pct = 86;
    logic [7:0] cur_sync      = SYNC_RESET;
    logic [7:0] cur_esc       = ESCAPE_RESET;
    int         stream_bytes  = 0;
    int         noise_bytes   = 0;
    int         settings_used = 0;

    logic [7:0] sync_set [NUM_SEGS];
    logic [7:0] esc_set  [NUM_SEGS];

    always #2 clk = ~clk;

    sync_escape_checksum_frame_receiver #(
        .MAX_FRAME (MAX_FRAME)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    sefr_event_check #(
        .MAX_FRAME (MAX_FRAME)
    ) event_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending),
        .frames_good    (frames_good),
        .frames_bad     (frames_bad),
        .frames_dropped (frames_dropped)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        stream_bytes++;
        @(negedge clk);
    endtask

    // hold off the sender until every predicted event has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (events_pending != 0);
    endtask

    task automatic write_regs(input logic [7:0] sync_v, input logic [7:0] esc_v);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SYNC;
        cfg_data  <= sync_v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_ESCAPE;
        cfg_data  <= esc_v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_sync = sync_v;
        cur_esc  = esc_v;
        settings_used++;
    endtask

    function automatic bit is_special(input logic [7:0] v);
        return (v == cur_sync) || (v == cur_esc);
    endfunction

    // a special value can only get through as escape plus (value - 1)
    function automatic bit can_encode(input logic [7:0] v);
        logic [7:0] pre;
        pre = v - 8'd1;
        return !is_special(v) || (cur_sync != cur_esc && !is_special(pre));
    endfunction

    function automatic logic [7:0] pick_body();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        while (!can_encode(v))
            v = 8'($urandom_range(255));
        return v;
    endfunction

    task automatic send_value(input logic [7:0] v);
        logic [7:0] pre;
        pre = v - 8'd1;
        if (is_special(v) ||
            (cur_sync != cur_esc && !is_special(pre) && $urandom_range(99) < 10))
        begin
            if ($urandom_range(99) < 20)
                send_byte(cur_esc);
            send_byte(cur_esc);
            send_byte(pre);
        end
        else
            send_byte(v);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        noise_bytes += n;
        repeat (n)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_frame();
        int         r;
        int         n_body;
        int         cut;
        bit         ends;
        logic [7:0] len;
        logic [7:0] v;
        logic [7:0] sum;
        logic [7:0] ck;
        do
        begin
            r = $urandom_range(99);
            if (r < 65)
                len = 8'($urandom_range(1, 12));
            else if (r < 75)
                len = 8'($urandom_range(13, MAX_FRAME - 4));
            else if (r < 82)
                len = 8'(MAX_FRAME - 3);          // ends right at the size limit
            else if (r < 86)
                len = 8'd0;
            else if (r < 90)
                len = 8'($urandom_range(MAX_FRAME - 2, 255));
            else
                len = 8'($urandom_range(1, 4));
        end
        while (!can_encode(len));
        ends   = (len >= 1) && (int'(len) + 3 <= MAX_FRAME);
        n_body = ends ? int'(len) + 3 : MAX_FRAME + 1;
        cut    = ($urandom_range(99) < 8) ? int'($urandom_range(n_body)) : -1;
        send_byte(cur_sync);
        sum = 8'd0;
        for (int i = 0; i < n_body; i++)
        begin
            if (i == cut)
            begin
                // abandon the frame, sometimes with an escape still pending
                if (cur_sync != cur_esc && $urandom_range(1) == 1)
                    send_byte(cur_esc);
                return;
            end
            v = (i == LEN_INDEX) ? len : pick_body();
            send_value(v);
            sum = sum + v;
        end
        if (ends)
        begin
            ck = sum;
            if ($urandom_range(99) < 20)
                ck = sum ^ 8'($urandom_range(1, 255));
            if (can_encode(ck))
                send_value(ck);
            else
                send_byte(pick_body());
        end
    endtask

    task automatic run_segment(input int n_bytes);
        int target;
        target = stream_bytes - noise_bytes + n_bytes;
        while (stream_bytes - noise_bytes < target)
        begin
            if ($urandom_range(99) < 15)
                send_noise();
            else
                send_frame();
            if ($urandom_range(99) < 3)
                drain();
        end
    endtask

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        sync_set = '{8'hE0, 8'h00, 8'hFF, 8'h55, 8'h00, 8'h7E};
        esc_set  = '{8'hD0, 8'hFF, 8'h00, 8'h55, 8'h00, 8'h7D};
        sync_set[4] = 8'($urandom_range(255));
        esc_set[4]  = 8'($urandom_range(255));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset register values: ignored bytes, good frame with an escaped
        // wrap to zero, escape after escape, sync while escape pending,
        // bad checksum, then a byte after the frame has closed
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hE0);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h01);
        send_byte(8'hD0);
        send_byte(8'hFF);
        send_byte(8'h04);
        send_byte(8'hE0);
        send_byte(8'hD0);
        send_byte(8'hD0);
        send_byte(8'h05);
        send_byte(8'hD0);
        send_byte(8'hE0);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h01);
        send_byte(8'h30);
        send_byte(8'h00);
        send_byte(8'hAA);

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            drain();
            write_regs(sync_set[seg], esc_set[seg]);
            if (seg < 2)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 86;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_segment(SEG_BYTES);
        end

        drain();
        repeat (8) @(negedge clk);

        $display("covered %0d bytes (%0d of them noise) under %0d register settings",
                 stream_bytes, noise_bytes, settings_used);
        $display("frames closed: %0d good, %0d checksum errors, %0d dropped on overflow",
                 frames_good, frames_bad, frames_dropped);
        if (mismatch_count == 0 && events_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
src/sefr_pkg.sv
src/sefr_in_reg.sv
src/sefr_core.sv
src/sefr_out_reg.sv
src/sync_escape_checksum_frame_receiver.sv
tb/sv/sefr_event_check.sv
tb/sv/tb_top.sv
